/* hw/rtl/frwe_pkg.sv */
package frwe_pkg;

	localparam int DEPTH       = 32;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int SIZE_W      = $clog2(DEPTH + 1);
	localparam int TS_W        = 64;
	localparam int RATE_W      = 7;
	localparam int CFG_W       = 6;
	localparam int FILL_OUT_W  = 6;
	localparam int RATE_MAX_I  = 120;
	localparam int CLEAR_FLOOR = 10;
	localparam int NS_PER_SEC_I = 1000000000;

	localparam logic [RATE_W-1:0] RATE_LIMIT = RATE_W'(RATE_MAX_I);
	localparam logic [TS_W-1:0]   NS_PER_SEC = TS_W'(NS_PER_SEC_I);
	localparam logic [TS_W-1:0]   FAST_MAX   = NS_PER_SEC / TS_W'(RATE_MAX_I + 1);

	localparam int TOTAL_W    = $clog2(DEPTH * RATE_MAX_I + 1);
	localparam int DIV_Q_W    = $clog2((DEPTH + 1) * RATE_MAX_I + 1);
	localparam int DIV_NUM_W  = $clog2(NS_PER_SEC_I + 1);
	localparam int DIV_DEN_W  = DIV_NUM_W + RATE_W - 1;
	localparam int STEP_W     = $clog2(DIV_Q_W + 1);

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'((DEPTH < 32) ? DEPTH : 32);

	localparam logic OP_TRIGGER = 1'b0;
	localparam logic OP_QUERY   = 1'b1;

	typedef struct packed {
		logic            opcode;
		logic [TS_W-1:0] time_stamp;
	} req_t;

	typedef struct packed {
		logic [RATE_W-1:0]     fps_value;
		logic                  stable;
		logic [FILL_OUT_W-1:0] fill_count;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_CHECK,
		S_RATE_DIV,
		S_AVG,
		S_AVG_DIV,
		S_DECIDE,
		S_SMOOTH_DIV,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIV_RATE,
		DIV_AVG,
		DIV_SMOOTH
	} div_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     cfg_load;
		logic     sum_step;
		logic     rate_direct;
		logic     div_start;
		div_sel_t div_sel;
		logic     rate_take;
		logic     avg_zero;
		logic     avg_take;
		logic     apply;
		logic     smooth_take;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic cfg_ok;
		logic sum_last;
		logic rate_direct;
		logic div_busy;
		logic div_done;
		logic fill_zero;
		logic need_smooth;
	} status_t;

	function automatic logic [RATE_W-1:0] sat_rate(input logic [DIV_Q_W-1:0] v);
		return (v > DIV_Q_W'(RATE_LIMIT)) ? RATE_LIMIT : v[RATE_W-1:0];
	endfunction

endpackage

/* hw/rtl/frwe_div.sv */
module frwe_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [frwe_pkg::DIV_NUM_W-1:0]      dividend,
	input  logic [frwe_pkg::DIV_DEN_W-1:0]      divisor,
	input  logic [frwe_pkg::STEP_W-1:0]         steps,
	output logic                                busy,
	output logic                                done,
	output logic [frwe_pkg::DIV_Q_W-1:0]        quotient
);

	logic                               busy_q;
	logic                               done_q;
	logic [frwe_pkg::STEP_W-1:0]        cnt_q;
	logic [frwe_pkg::DIV_NUM_W-1:0]     rem_q;
	logic [frwe_pkg::DIV_DEN_W-1:0]     den_q;
	logic [frwe_pkg::DIV_Q_W-1:0]       quo_q;
	logic                               ge;

	assign ge = {{(frwe_pkg::DIV_DEN_W - frwe_pkg::DIV_NUM_W){1'b0}}, rem_q} >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - frwe_pkg::STEP_W'(1);
				if (cnt_q == frwe_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q[frwe_pkg::DIV_NUM_W-1:0];
			end
			quo_q <= {quo_q[frwe_pkg::DIV_Q_W-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hw/rtl/frwe_dpath.sv */
module frwe_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  frwe_pkg::req_t                req,
	input  logic [frwe_pkg::CFG_W-1:0]    cfg_window_size,
	input  frwe_pkg::cmd_t                cmd,
	output frwe_pkg::status_t             st,
	output frwe_pkg::rsp_t                rsp
);

	logic                               op_q;
	logic [frwe_pkg::TS_W-1:0]          ts_q;
	logic [frwe_pkg::TS_W-1:0]          delta_q;
	logic [frwe_pkg::TS_W-1:0]          last_q;
	logic [frwe_pkg::RATE_W-1:0]        rate_q;
	logic [frwe_pkg::TOTAL_W-1:0]       avg_q;
	logic [frwe_pkg::RATE_W-1:0]        win_q [frwe_pkg::DEPTH];
	logic [frwe_pkg::RATE_W-1:0]        win_trig [frwe_pkg::DEPTH];
	logic [frwe_pkg::TOTAL_W-1:0]       total_q;
	logic [frwe_pkg::TOTAL_W-1:0]       total_trig;
	logic [frwe_pkg::SIZE_W-1:0]        fill_q;
	logic [frwe_pkg::SIZE_W-1:0]        fill_trig;
	logic [frwe_pkg::SIZE_W-1:0]        size_q;
	logic [frwe_pkg::IDX_W-1:0]         sum_idx_q;
	logic [frwe_pkg::IDX_W-1:0]         top_idx;
	logic [frwe_pkg::IDX_W-1:0]         rd_idx;
	logic [frwe_pkg::RATE_W-1:0]        rd_data;
	logic [frwe_pkg::TOTAL_W-1:0]       rate_ext;
	logic                               drop;
	logic [frwe_pkg::DIV_NUM_W-1:0]     div_dividend;
	logic [frwe_pkg::DIV_DEN_W-1:0]     div_divisor;
	logic [frwe_pkg::STEP_W-1:0]        div_steps;
	logic                               div_busy;
	logic                               div_done;
	logic [frwe_pkg::DIV_Q_W-1:0]       div_q;
	logic [frwe_pkg::RATE_W-1:0]        res_value_q;
	logic                               res_stable_q;
	logic [frwe_pkg::SIZE_W-1:0]        res_fill_q;
	frwe_pkg::rsp_t                     rsp_q;

	assign top_idx  = frwe_pkg::IDX_W'(size_q - frwe_pkg::SIZE_W'(1));
	assign rd_idx   = cmd.sum_step ? sum_idx_q : top_idx;
	assign rd_data  = win_q[rd_idx];
	assign rate_ext = frwe_pkg::TOTAL_W'(rate_q);
	assign drop     = (rate_ext < (avg_q >> 1)) && (avg_q > frwe_pkg::TOTAL_W'(frwe_pkg::CLEAR_FLOOR));

	assign st.cfg_ok      = (cfg_window_size != '0) && (int'(cfg_window_size) <= frwe_pkg::DEPTH);
	assign st.sum_last    = (sum_idx_q == top_idx);
	assign st.rate_direct = (delta_q <= frwe_pkg::FAST_MAX) || (delta_q > frwe_pkg::NS_PER_SEC);
	assign st.div_busy    = div_busy;
	assign st.div_done    = div_done;
	assign st.fill_zero   = (fill_q == '0);
	assign st.need_smooth = (op_q == frwe_pkg::OP_QUERY) && !drop && (rate_ext < avg_q);

	always_comb begin
		unique case (cmd.div_sel)
			frwe_pkg::DIV_RATE: begin
				div_dividend = frwe_pkg::DIV_NUM_W'(frwe_pkg::NS_PER_SEC);
				div_divisor  = frwe_pkg::DIV_DEN_W'(delta_q[frwe_pkg::DIV_NUM_W-1:0])
					<< (frwe_pkg::RATE_W - 1);
				div_steps    = frwe_pkg::STEP_W'(frwe_pkg::RATE_W);
			end
			frwe_pkg::DIV_AVG: begin
				div_dividend = frwe_pkg::DIV_NUM_W'(total_q);
				div_divisor  = frwe_pkg::DIV_DEN_W'(fill_q) << (frwe_pkg::DIV_Q_W - 1);
				div_steps    = frwe_pkg::STEP_W'(frwe_pkg::DIV_Q_W);
			end
			frwe_pkg::DIV_SMOOTH: begin
				div_dividend = frwe_pkg::DIV_NUM_W'(total_q) + frwe_pkg::DIV_NUM_W'(rate_q);
				div_divisor  = (frwe_pkg::DIV_DEN_W'(fill_q) + frwe_pkg::DIV_DEN_W'(1))
					<< (frwe_pkg::DIV_Q_W - 1);
				div_steps    = frwe_pkg::STEP_W'(frwe_pkg::DIV_Q_W);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
				div_steps    = '0;
			end
		endcase
	end

	frwe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		win_trig[0] = rate_q;
		for (int i = 1; i < frwe_pkg::DEPTH; i++) begin
			if (drop) begin
				win_trig[i] = '0;
			end else if (i < int'(size_q)) begin
				win_trig[i] = win_q[i-1];
			end else begin
				win_trig[i] = win_q[i];
			end
		end
		if (drop) begin
			total_trig = rate_ext;
			fill_trig  = frwe_pkg::SIZE_W'(1);
		end else begin
			total_trig = total_q - frwe_pkg::TOTAL_W'(rd_data) + rate_ext;
			fill_trig  = (fill_q < size_q) ? fill_q + frwe_pkg::SIZE_W'(1) : fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < frwe_pkg::DEPTH; i++) begin
				win_q[i] <= '0;
			end
			total_q   <= '0;
			fill_q    <= '0;
			size_q    <= frwe_pkg::SIZE_RESET;
			last_q    <= '0;
			sum_idx_q <= '0;
		end else begin
			if (cmd.cfg_load) begin
				size_q    <= frwe_pkg::SIZE_W'(cfg_window_size);
				total_q   <= '0;
				sum_idx_q <= '0;
				if (fill_q > frwe_pkg::SIZE_W'(cfg_window_size)) begin
					fill_q <= frwe_pkg::SIZE_W'(cfg_window_size);
				end
			end
			if (cmd.sum_step) begin
				total_q   <= total_q + frwe_pkg::TOTAL_W'(rd_data);
				sum_idx_q <= sum_idx_q + frwe_pkg::IDX_W'(1);
			end
			if (cmd.apply) begin
				if (op_q == frwe_pkg::OP_TRIGGER) begin
					win_q   <= win_trig;
					total_q <= total_trig;
					fill_q  <= fill_trig;
					last_q  <= ts_q;
				end else if (drop) begin
					for (int i = 0; i < frwe_pkg::DEPTH; i++) begin
						win_q[i] <= '0;
					end
					total_q <= '0;
					fill_q  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q    <= req.opcode;
			ts_q    <= req.time_stamp;
			delta_q <= req.time_stamp - last_q;
		end
		if (cmd.rate_direct) begin
			rate_q <= (delta_q > frwe_pkg::NS_PER_SEC) ? '0 : frwe_pkg::RATE_LIMIT;
		end else if (cmd.rate_take) begin
			rate_q <= div_q[frwe_pkg::RATE_W-1:0];
		end
		if (cmd.avg_zero) begin
			avg_q <= '0;
		end else if (cmd.avg_take) begin
			avg_q <= div_q[frwe_pkg::TOTAL_W-1:0];
		end
		if (cmd.apply) begin
			if (op_q == frwe_pkg::OP_TRIGGER) begin
				res_value_q  <= rate_q;
				res_stable_q <= 1'b0;
				res_fill_q   <= fill_trig;
			end else if (drop) begin
				res_value_q  <= rate_q;
				res_stable_q <= 1'b0;
				res_fill_q   <= '0;
			end else begin
				res_value_q  <= frwe_pkg::sat_rate(frwe_pkg::DIV_Q_W'(avg_q));
				res_stable_q <= (fill_q >= (size_q >> 1));
				res_fill_q   <= fill_q;
			end
		end else if (cmd.smooth_take) begin
			res_value_q <= frwe_pkg::sat_rate(div_q);
		end
		if (cmd.out_load) begin
			rsp_q.fps_value  <= res_value_q;
			rsp_q.stable     <= res_stable_q;
			rsp_q.fill_count <= frwe_pkg::FILL_OUT_W'(res_fill_q);
		end
	end

	assign rsp = rsp_q;

endmodule

/* hw/rtl/frwe_ctrl.sv */
module frwe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  frwe_pkg::status_t  st,
	output frwe_pkg::cmd_t     cmd
);

	frwe_pkg::state_t state_q;
	frwe_pkg::state_t state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frwe_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			frwe_pkg::S_IDLE: begin
				if (cfg_valid) begin
					if (st.cfg_ok) begin
						state_d = frwe_pkg::S_SUM;
					end
				end else if (req_valid) begin
					state_d = frwe_pkg::S_CHECK;
				end
			end
			frwe_pkg::S_SUM: begin
				if (st.sum_last) begin
					state_d = frwe_pkg::S_IDLE;
				end
			end
			frwe_pkg::S_CHECK: begin
				state_d = st.rate_direct ? frwe_pkg::S_AVG : frwe_pkg::S_RATE_DIV;
			end
			frwe_pkg::S_RATE_DIV: begin
				if (st.div_done) begin
					state_d = frwe_pkg::S_AVG;
				end
			end
			frwe_pkg::S_AVG: begin
				state_d = st.fill_zero ? frwe_pkg::S_DECIDE : frwe_pkg::S_AVG_DIV;
			end
			frwe_pkg::S_AVG_DIV: begin
				if (st.div_done) begin
					state_d = frwe_pkg::S_DECIDE;
				end
			end
			frwe_pkg::S_DECIDE: begin
				state_d = st.need_smooth ? frwe_pkg::S_SMOOTH_DIV : frwe_pkg::S_DONE;
			end
			frwe_pkg::S_SMOOTH_DIV: begin
				if (st.div_done) begin
					state_d = frwe_pkg::S_DONE;
				end
			end
			frwe_pkg::S_DONE: begin
				if (!out_valid_q || rsp_ready) begin
					state_d = frwe_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = frwe_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.div_sel = frwe_pkg::DIV_RATE;
		req_ready   = 1'b0;
		cfg_ready   = 1'b0;
		unique case (state_q)
			frwe_pkg::S_IDLE: begin
				cfg_ready    = 1'b1;
				req_ready    = !cfg_valid;
				cmd.cfg_load = cfg_valid && st.cfg_ok;
				cmd.load_in  = req_valid && !cfg_valid;
			end
			frwe_pkg::S_SUM: begin
				cmd.sum_step = 1'b1;
			end
			frwe_pkg::S_CHECK: begin
				cmd.rate_direct = st.rate_direct;
				cmd.div_start   = !st.rate_direct;
				cmd.div_sel     = frwe_pkg::DIV_RATE;
			end
			frwe_pkg::S_RATE_DIV: begin
				cmd.rate_take = st.div_done;
			end
			frwe_pkg::S_AVG: begin
				cmd.avg_zero  = st.fill_zero;
				cmd.div_start = !st.fill_zero;
				cmd.div_sel   = frwe_pkg::DIV_AVG;
			end
			frwe_pkg::S_AVG_DIV: begin
				cmd.avg_take = st.div_done;
			end
			frwe_pkg::S_DECIDE: begin
				cmd.apply     = 1'b1;
				cmd.div_start = st.need_smooth;
				cmd.div_sel   = frwe_pkg::DIV_SMOOTH;
			end
			frwe_pkg::S_SMOOTH_DIV: begin
				cmd.smooth_take = st.div_done;
			end
			frwe_pkg::S_DONE: begin
				cmd.out_load = !out_valid_q || rsp_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.div_busy)
		else $error("divider started while busy");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == frwe_pkg::S_RATE_DIV || state_q == frwe_pkg::S_AVG_DIV ||
			state_q == frwe_pkg::S_SMOOTH_DIV))
		else $error("divider finished outside a wait state");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("pending result overwritten");

	a_req_starts_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == frwe_pkg::S_CHECK))
		else $error("accepted request not started");

endmodule

/* hw/rtl/frame_rate_window_estimator_top.sv */
// Frame rate window estimator.
// req channel (valid/ready) carries one beat per frame trigger or query with
// a nanosecond time stamp; rsp channel (valid/ready) returns one beat per
// request: fps value, stable flag and window fill count after the request.
// cfg channel (valid/ready) writes the window size; out-of-range sizes are
// dropped. A legal write recomputes the running total by walking the sample
// window, one entry per cycle, for window_size entries; requests wait meanwhile.
// One request is processed at a time. A request needs up to three divides
// (rate, average, smoothed estimate) and may need none. The divides share one
// radix-2 divider that produces one quotient bit per cycle. A new request can
// be taken once the result has moved to the output register and the
// controller is back in idle, so a stalled receiver holds one result while
// the next request runs; the block waits only when a second result is ready
// before the first is taken.
// Reset clears the window, total, fill count and last trigger time and sets
// the window size to 32.
module frame_rate_window_estimator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  frwe_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output frwe_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frwe_pkg::CFG_W-1:0]    cfg_window_size
);

	frwe_pkg::cmd_t    cmd;
	frwe_pkg::status_t st;

	frwe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.st        (st),
		.cmd       (cmd)
	);

	frwe_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req),
		.cfg_window_size (cfg_window_size),
		.cmd             (cmd),
		.st              (st),
		.rsp             (rsp)
	);

endmodule
